FILE: src/jrs_pkg.sv
`timescale 1ns / 1ps

package jrs_pkg;

   // Table size and derived widths
   localparam int MAX_JOINTS = 32;
   localparam int CNT_W      = $clog2(MAX_JOINTS + 1);

   // Field widths
   localparam int ID_W    = 6;
   localparam int POS_W   = 20;
   localparam int SPEED_W = 16;
   localparam int WT_W    = 17;
   localparam int STEP_W  = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 17;

   localparam logic [WT_W-1:0] WEIGHT_ONE = 17'd65536;
   localparam logic [WT_W-1:0] WEIGHT_TOL = 17'd655;

   typedef enum logic [1:0] {
      ACT_CLEAR  = 2'd0,
      ACT_APPEND = 2'd1,
      ACT_TICK   = 2'd2,
      ACT_NONE   = 2'd3
   } action_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_WEIGHT_STEP = 2'd0,
      CSR_BASE_STEP   = 2'd1,
      CSR_MAX_STEP    = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      PH_RAMP_UP,
      PH_SLEW_HOLD,
      PH_RAMP_DOWN,
      PH_SLEW
   } phase_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LIMIT,
      ST_UPDATE,
      ST_EMIT
   } state_type;

   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_LIMIT,
      CELL_SLEW,
      CELL_RAMP,
      CELL_ROTATE
   } cell_op_type;

   typedef struct packed {
      logic [ID_W-1:0]           joint;
      logic signed [POS_W-1:0]   act_pos;
      logic signed [POS_W-1:0]   goal_pos;
      logic signed [SPEED_W-1:0] speed;
      logic [WT_W-1:0]           act_wt;
      logic [WT_W-1:0]           goal_wt;
      logic [STEP_W-1:0]         lim;
      logic                      done;
   } entry_type;

   typedef struct packed {
      cell_op_type       op;
      logic              ramp_up;
      logic [WT_W-1:0]   weight_step;
      logic [STEP_W-1:0] base_step;
      logic [STEP_W-1:0] max_step;
   } cell_ctrl_type;

   typedef struct packed {
      logic [ID_W-1:0]         entry_joint;
      logic signed [POS_W-1:0] command_position;
      logic [WT_W-1:0]         command_weight;
      logic                    command_valid;
      logic                    accepted;
      logic                    last;
   } rsp_payload_type;

endpackage

FILE: src/jrs_req_if.sv
`timescale 1ns / 1ps

interface jrs_req_if;
   import jrs_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [1:0]                action;
   logic [ID_W-1:0]           joint_id;
   logic signed [POS_W-1:0]   current_position;
   logic signed [POS_W-1:0]   target_position;
   logic signed [SPEED_W-1:0] speed;
   logic [WT_W-1:0]           start_weight;
   logic [WT_W-1:0]           goal_weight;
   logic                      last_of_set;

   modport source (
      output valid, action, joint_id, current_position, target_position, speed,
             start_weight, goal_weight, last_of_set,
      input  ready
   );

   modport sink (
      input  valid, action, joint_id, current_position, target_position, speed,
             start_weight, goal_weight, last_of_set,
      output ready
   );

endinterface

FILE: src/jrs_rsp_if.sv
`timescale 1ns / 1ps

interface jrs_rsp_if;
   import jrs_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [ID_W-1:0]         entry_joint;
   logic signed [POS_W-1:0] command_position;
   logic [WT_W-1:0]         command_weight;
   logic                    command_valid;
   logic                    accepted;
   logic                    last;

   modport source (
      output valid, entry_joint, command_position, command_weight, command_valid,
             accepted, last,
      input  ready
   );

   modport sink (
      input  valid, entry_joint, command_position, command_weight, command_valid,
             accepted, last,
      output ready
   );

endinterface

FILE: src/jrs_cell.sv
`timescale 1ns / 1ps

module jrs_cell (
   input  logic                   clock,
   input  jrs_pkg::cell_ctrl_type ctrl,
   input  logic                   load_en,
   input  jrs_pkg::entry_type     load_data,
   input  jrs_pkg::entry_type     next_entry,
   output jrs_pkg::entry_type     entry
);
   import jrs_pkg::*;

   entry_type entry_ff, entry_in;

   logic [SPEED_W-1:0]        speed_mag;
   logic [2*STEP_W-1:0]       product;
   logic [2*STEP_W-9:0]       scaled;
   logic [STEP_W-1:0]         lim_new;
   logic signed [POS_W:0]     delta;
   logic signed [POS_W:0]     lim_s;
   logic signed [POS_W:0]     step;
   logic signed [POS_W:0]     pos_sum;
   logic signed [WT_W+1:0]    wt_sum;
   logic [WT_W-1:0]           wt_new;
   logic signed [WT_W+1:0]    wt_diff;
   logic signed [WT_W+1:0]    tol_s;

   always_comb begin
      // speed magnitude, zero stands for unit speed (1.0 in Q8.8)
      speed_mag = entry_ff.speed[SPEED_W-1] ? SPEED_W'(-entry_ff.speed)
                                            : SPEED_W'(entry_ff.speed);
      if (speed_mag == '0) begin
         speed_mag = SPEED_W'(256);
      end
      product = {{STEP_W{1'b0}}, ctrl.base_step} * {{STEP_W{1'b0}}, speed_mag};
      scaled  = product[2*STEP_W-1:8];
      if (scaled > {8'd0, ctrl.max_step}) begin
         lim_new = ctrl.max_step;
      end else begin
         lim_new = scaled[STEP_W-1:0];
      end

      // position slew, step clamped to +/- lim
      delta = $signed({entry_ff.goal_pos[POS_W-1], entry_ff.goal_pos})
            - $signed({entry_ff.act_pos[POS_W-1], entry_ff.act_pos});
      lim_s = $signed({{(POS_W+1-STEP_W){1'b0}}, entry_ff.lim});
      if (delta > lim_s) begin
         step = lim_s;
      end else if (delta < -lim_s) begin
         step = -lim_s;
      end else begin
         step = delta;
      end
      pos_sum = $signed({entry_ff.act_pos[POS_W-1], entry_ff.act_pos}) + step;

      // weight ramp, saturate to [0, 1.0]
      if (ctrl.ramp_up) begin
         wt_sum = $signed({2'b00, entry_ff.act_wt}) + $signed({2'b00, ctrl.weight_step});
      end else begin
         wt_sum = $signed({2'b00, entry_ff.act_wt}) - $signed({2'b00, ctrl.weight_step});
      end
      if (wt_sum < 0) begin
         wt_new = '0;
      end else if (wt_sum > $signed({2'b00, WEIGHT_ONE})) begin
         wt_new = WEIGHT_ONE;
      end else begin
         wt_new = wt_sum[WT_W-1:0];
      end
      wt_diff = $signed({2'b00, wt_new}) - $signed({2'b00, entry_ff.goal_wt});
      tol_s   = $signed({2'b00, WEIGHT_TOL});

      entry_in = entry_ff;
      if (load_en) begin
         entry_in = load_data;
      end else begin
         case (ctrl.op)
            CELL_HOLD: begin
               entry_in = entry_ff;
            end
            CELL_LIMIT: begin
               entry_in.lim = lim_new;
            end
            CELL_SLEW: begin
               entry_in.act_pos = POS_W'(pos_sum);
               entry_in.done    = !(delta > lim_s || delta < -lim_s);
            end
            CELL_RAMP: begin
               entry_in.act_wt = wt_new;
               entry_in.done   = !(wt_diff > tol_s || wt_diff < -tol_s);
            end
            CELL_ROTATE: begin
               entry_in = next_entry;
            end
            default: begin
               entry_in = entry_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

FILE: src/joint_ramp_sequencer_unit.sv
`timescale 1ns / 1ps

// Channel  Direction  Contents
// req_chan in        action, joint_id, positions, speed, weights, last_of_set
// rsp_chan out       entry_joint, command_position/weight, command_valid, accepted, last
// csr_*    in        weight_step, base_position_step, max_position_step writes
//
// Clear, append and idle ticks each give one transaction.
// A running tick forms each cell's step limit in ST_LIMIT, updates every cell in
// ST_UPDATE, then in ST_EMIT rotates the ring of cells through one full turn past
// the head, which emits one command per stored entry.
// Output stalls hold the ring rotation; a stalled result sits in the output register.
// Synchronous reset clears the count, run state and output valid; the table is undefined.
module joint_ramp_sequencer_unit (
   input  logic                          clock,
   input  logic                          reset,
   jrs_req_if.sink                       req_chan,
   jrs_rsp_if.source                     rsp_chan,
   input  logic                          csr_write_en,
   input  logic [jrs_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [jrs_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import jrs_pkg::*;

   localparam logic [ID_W:0]    ID_LIMIT = (ID_W+1)'(MAX_JOINTS);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_JOINTS);
   localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(MAX_JOINTS - 1);

   // Control and status
   state_type         state_ff, state_in;
   phase_type         phase_ff, phase_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  emit_idx_ff, emit_idx_in;
   logic              running_ff, running_in;
   logic              reached_ff, reached_in;
   logic              all_done_ff, all_done_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_payload_type   rsp_data_ff, rsp_data_in;

   // Configuration
   logic [WT_W-1:0]   weight_step_ff;
   logic [STEP_W-1:0] base_step_ff;
   logic [STEP_W-1:0] max_step_ff;

   // Cell ring
   cell_ctrl_type     cell_ctrl;
   entry_type         cell_q [MAX_JOINTS];
   entry_type         append_data;
   logic              append_go;
   logic [CNT_W-1:0]  append_slot;

   logic              req_take;
   logic              out_free;
   logic              emit_now;
   logic              advance;
   logic              done_all;
   logic signed [WT_W+1:0] head_gap;
   logic [CNT_W-1:0]  new_count;
   logic [WT_W-1:0]   init_wt_sat;
   logic [WT_W-1:0]   goal_wt_sat;

   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE) && out_free;
   assign req_take = req_chan.valid && req_chan.ready;

   // saturate stored weights to 1.0
   assign init_wt_sat = (req_chan.start_weight > WEIGHT_ONE) ? WEIGHT_ONE
                                                             : req_chan.start_weight;
   assign goal_wt_sat = (req_chan.goal_weight > WEIGHT_ONE) ? WEIGHT_ONE
                                                            : req_chan.goal_weight;

   always_comb begin
      append_data          = '0;
      append_data.joint    = req_chan.joint_id;
      append_data.act_pos  = req_chan.current_position;
      append_data.goal_pos = req_chan.target_position;
      append_data.speed    = req_chan.speed;
      append_data.act_wt   = init_wt_sat;
      append_data.goal_wt  = goal_wt_sat;
   end

   assign append_slot = count_ff;

   // goal minus active weight of the head entry picks the phase
   assign head_gap = $signed({2'b00, cell_q[0].goal_wt}) - $signed({2'b00, cell_q[0].act_wt});

   assign emit_now = (state_ff == ST_EMIT) && (emit_idx_ff < count_ff);
   assign advance  = (state_ff == ST_EMIT) && (!emit_now || out_free);
   assign done_all = all_done_ff && (!emit_now || cell_q[0].done);

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      count_in     = count_ff;
      emit_idx_in  = emit_idx_ff;
      running_in   = running_ff;
      reached_in   = reached_ff;
      all_done_in  = all_done_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_data_in  = rsp_data_ff;
      append_go    = 1'b0;
      new_count    = count_ff;

      cell_ctrl.op          = CELL_HOLD;
      cell_ctrl.ramp_up     = (phase_ff == PH_RAMP_UP);
      cell_ctrl.weight_step = weight_step_ff;
      cell_ctrl.base_step   = base_step_ff;
      cell_ctrl.max_step    = max_step_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               // default single transaction: all zero, last set
               rsp_valid_in = 1'b1;
               rsp_data_in  = '0;
               rsp_data_in.last = 1'b1;
               case (action_type'(req_chan.action))
                  ACT_CLEAR: begin
                     if (!running_ff) begin
                        rsp_data_in.accepted = 1'b1;
                        count_in = '0;
                     end
                  end
                  ACT_APPEND: begin
                     if (!running_ff) begin
                        rsp_data_in.accepted = 1'b1;
                        if ({1'b0, req_chan.joint_id} < ID_LIMIT && count_ff < CNT_FULL) begin
                           append_go = 1'b1;
                           new_count = count_ff + CNT_W'(1);
                        end
                        count_in = new_count;
                        if (req_chan.last_of_set) begin
                           running_in = (new_count != '0);
                           reached_in = 1'b0;
                        end
                     end
                  end
                  ACT_TICK: begin
                     if (running_ff && count_ff != '0) begin
                        // hold the response until the ring emits
                        rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
                        rsp_data_in  = rsp_data_ff;
                        state_in     = ST_LIMIT;
                        if (head_gap > $signed({2'b00, WEIGHT_TOL})) begin
                           phase_in = PH_RAMP_UP;
                        end else if (head_gap < -$signed({2'b00, WEIGHT_TOL})) begin
                           phase_in = reached_ff ? PH_RAMP_DOWN : PH_SLEW_HOLD;
                        end else begin
                           phase_in = PH_SLEW;
                        end
                     end
                  end
                  default: begin
                     rsp_data_in.last = 1'b1;
                  end
               endcase
            end
         end
         ST_LIMIT: begin
            cell_ctrl.op = CELL_LIMIT;
            state_in     = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (phase_ff == PH_RAMP_UP || phase_ff == PH_RAMP_DOWN) begin
               cell_ctrl.op = CELL_RAMP;
            end else begin
               cell_ctrl.op = CELL_SLEW;
            end
            state_in    = ST_EMIT;
            emit_idx_in = '0;
            all_done_in = 1'b1;
         end
         ST_EMIT: begin
            if (advance) begin
               cell_ctrl.op = CELL_ROTATE;
               emit_idx_in  = emit_idx_ff + CNT_W'(1);
               all_done_in  = done_all;
               if (emit_now) begin
                  rsp_valid_in                 = 1'b1;
                  rsp_data_in.entry_joint      = cell_q[0].joint;
                  rsp_data_in.command_position = cell_q[0].act_pos;
                  rsp_data_in.command_weight   = cell_q[0].act_wt;
                  rsp_data_in.command_valid    = 1'b1;
                  rsp_data_in.accepted         = 1'b0;
                  rsp_data_in.last             = (emit_idx_ff + CNT_W'(1) == count_ff);
               end
               if (emit_idx_ff == LAST_IDX) begin
                  // full turn done: drop back to idle and settle the run state
                  state_in = ST_IDLE;
                  case (phase_ff)
                     PH_SLEW_HOLD: begin
                        reached_in = done_all;
                     end
                     PH_RAMP_DOWN: begin
                        if (done_all) begin
                           running_in = 1'b0;
                           reached_in = 1'b0;
                        end
                     end
                     PH_SLEW: begin
                        if (done_all) begin
                           running_in = 1'b0;
                        end
                     end
                     default: begin
                        running_in = running_ff;
                     end
                  endcase
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_SLEW;
         count_ff     <= '0;
         emit_idx_ff  <= '0;
         running_ff   <= 1'b0;
         reached_ff   <= 1'b0;
         all_done_ff  <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         emit_idx_ff  <= emit_idx_in;
         running_ff   <= running_in;
         reached_ff   <= reached_in;
         all_done_ff  <= all_done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   // Configuration registers; unknown indexes are ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         weight_step_ff <= WT_W'(328);
         base_step_ff   <= STEP_W'(66);
         max_step_ff    <= STEP_W'(655);
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_WEIGHT_STEP: weight_step_ff <= csr_wdata[WT_W-1:0];
            CSR_BASE_STEP:   base_step_ff   <= csr_wdata[STEP_W-1:0];
            CSR_MAX_STEP:    max_step_ff    <= csr_wdata[STEP_W-1:0];
            default: begin
               weight_step_ff <= weight_step_ff;
            end
         endcase
      end
   end

   // Ring of cells: each hands its entry to the cell below while rotating,
   // the head passes its entry round to the tail.
   for (genvar i = 0; i < MAX_JOINTS; i++) begin : g_cell
      jrs_cell u_cell (
         .clock      (clock),
         .ctrl       (cell_ctrl),
         .load_en    (append_go && (append_slot == CNT_W'(i))),
         .load_data  (append_data),
         .next_entry (cell_q[(i + 1) % MAX_JOINTS]),
         .entry      (cell_q[i])
      );
   end

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.entry_joint      = rsp_data_ff.entry_joint;
   assign rsp_chan.command_position = rsp_data_ff.command_position;
   assign rsp_chan.command_weight   = rsp_data_ff.command_weight;
   assign rsp_chan.command_valid    = rsp_data_ff.command_valid;
   assign rsp_chan.accepted         = rsp_data_ff.accepted;
   assign rsp_chan.last             = rsp_data_ff.last;

endmodule
